// ----- hdl/hpw_pkg.sv -----
// Shared types, widths and codes for the histogram peak window block.
package hpw_pkg;

  localparam int MAX_BINS_DEF = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Moment sums over a seed window of at most 511 bins, offsets within +-255.
  localparam int S0_W   = 41;
  localparam int S1_W   = 50;
  localparam int S2_W   = 57;
  localparam int MEAN_W = 24;
  localparam int VAR_W  = 48;
  localparam int ROOT_W = 24;
  localparam int SIG_W  = 39;
  localparam int HALF_W = 43;
  localparam int CEN_W  = 42;
  localparam int SPAN_W = 42;
  localparam int DIV_W  = 88;
  localparam int MUL_A_W = 39;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // 0.35 in Q.16
  localparam logic [14:0] FALLBACK_Q16 = 15'd22938;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_COUNT,
    REG_AXIS_START,
    REG_BIN_SIZE,
    REG_SEED_HALF,
    REG_SIGMA_MULT,
    REG_MIN_HALF,
    REG_MAX_HALF
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_GO,
    ST_SCAN,
    ST_DIVM_GO,
    ST_DIVM,
    ST_DIVV_GO,
    ST_DIVV,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_SQRT_GO,
    ST_SQRT,
    ST_FINAL
  } ctrl_state_t;

  typedef enum logic [3:0] {
    MUL_MSQ,
    MUL_SIGMA,
    MUL_SEED,
    MUL_FALLBACK,
    MUL_HALF,
    MUL_MINLIM,
    MUL_MAXLIM,
    MUL_OFF,
    MUL_CENTRE,
    MUL_SPAN
  } mul_op_t;

  typedef enum logic {
    DIV_MEAN,
    DIV_VAR
  } div_sel_t;

  typedef struct packed {
    logic     load_en;
    logic     scan_go;
    logic     div_go;
    div_sel_t div_sel;
    logic     sqrt_go;
    logic     mul_go;
    mul_op_t  mul_op;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic scan_busy;
    logic div_busy;
    logic sqrt_busy;
    logic zero_run;
    logic prod_zero;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/hpw_div.sv -----
// Restoring divider, one quotient bit per cycle.
module hpw_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [hpw_pkg::DIV_W-1:0] dividend,
  input  logic [hpw_pkg::S0_W-1:0]  divisor,
  output logic                      busy,
  output logic                      done,
  output logic [hpw_pkg::DIV_W-1:0] quotient
);
  import hpw_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] dq;
  logic [S0_W-2:0]  rem;
  logic [CNT_W-1:0] cnt;
  logic [S0_W-1:0]  rem_sh;
  logic             ge;

  assign rem_sh   = {rem, dq[DIV_W-1]};
  assign ge       = rem_sh >= divisor;
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (go) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dq  <= dividend;
      rem <= '0;
      cnt <= CNT_W'(DIV_W - 1);
    end else if (busy) begin
      dq  <= {dq[DIV_W-2:0], ge};
      rem <= ge ? (S0_W-1)'(rem_sh - divisor) : rem_sh[S0_W-2:0];
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ----- hdl/hpw_sqrt.sv -----
// Integer square root, one root bit per cycle.
module hpw_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [hpw_pkg::VAR_W-1:0]  radicand,
  output logic                       busy,
  output logic [hpw_pkg::ROOT_W-1:0] root
);
  import hpw_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [VAR_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             ge;

  assign rem_sh = {rem, rad[VAR_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (busy && (cnt == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= CNT_W'(ROOT_W - 1);
    end else if (busy) begin
      rad  <= {rad[VAR_W-3:0], 2'b00};
      rem  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root <= {root[ROOT_W-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

// ----- hdl/hpw_datapath.sv -----
// Bin store, peak tracking, moment scan, divider and root, shared multiplier and result registers.
module hpw_datapath #(
  parameter int MAX_BINS = hpw_pkg::MAX_BINS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hpw_pkg::cmd_t       cmd,
  output hpw_pkg::status_t    stat,
  input  logic [10:0]         bin_count,
  input  logic signed [31:0]  axis_start,
  input  logic [30:0]         bin_size,
  input  logic [7:0]          seed_half_bins,
  input  logic [15:0]         sigma_multiple,
  input  logic [9:0]          min_half_bins,
  input  logic [9:0]          max_half_bins,
  input  logic                bin_valid,
  input  logic signed [31:0]  bin_weight,
  input  logic                res_stall,
  output logic                res_valid,
  output logic signed [31:0]  window_lo,
  output logic signed [31:0]  window_hi,
  output logic signed [31:0]  centroid,
  output logic [30:0]         spread,
  output logic                window_ok
);
  import hpw_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = AW + 1;
  localparam int XW = ((AW > 8) ? AW : 8) + 2;
  localparam int FW = 47;

  function automatic logic [31:0] sat32(input logic signed [FW-1:0] v);
    if (v > FW'(33'sd2147483647)) begin
      return 32'h7FFF_FFFF;
    end else if (v < -FW'(33'sd2147483648)) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // ---- load ----
  logic [CW-1:0]      count_eff;
  logic [CW-1:0]      load_index;
  logic [AW-1:0]      widx;
  logic [CW-1:0]      widx_inc;
  logic signed [31:0] peak_value;
  logic [AW-1:0]      peak_index;
  logic               any_pos;
  logic               accept;

  always_comb begin
    if (bin_count == '0) begin
      count_eff = CW'(1);
    end else if (int'(bin_count) > MAX_BINS) begin
      count_eff = CW'(MAX_BINS);
    end else begin
      count_eff = CW'(bin_count);
    end
  end

  assign accept   = cmd.load_en & bin_valid;
  assign widx     = (load_index >= CW'(MAX_BINS)) ? AW'(MAX_BINS - 1) : load_index[AW-1:0];
  assign widx_inc = CW'(widx) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      load_index <= '0;
      peak_value <= 32'sh8000_0000;
      peak_index <= '0;
      any_pos    <= 1'b0;
    end else if (accept) begin
      load_index <= widx_inc;
      if (bin_weight > peak_value) begin
        peak_value <= bin_weight;
        peak_index <= widx;
      end
      if (bin_weight > 32'sd0) begin
        any_pos <= 1'b1;
      end
    end
  end

  // ---- bin store ----
  logic [31:0]   mem [MAX_BINS];
  logic [31:0]   rd_data;
  logic [AW-1:0] addr;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[widx] <= bin_weight;
    end
    rd_data <= mem[addr];
  end

  // ---- moment scan ----
  logic [XW-1:0]      p_x, s_x, blo_x, bhi_x, cmax_x;
  logic [AW-1:0]      last_addr;
  logic               active;
  logic signed [8:0]  d0;
  logic               s1_v, s2_v, s3_v;
  logic signed [8:0]  s1_d, s2_d;
  logic [15:0]        s2_dd;
  logic signed [31:0] s2_w;
  logic signed [17:0] dd_full;
  logic signed [31:0] rd_s;
  logic signed [40:0] wd_full;
  logic               s3_pos;
  logic [30:0]        s3_w;
  logic signed [40:0] s3_wd;
  logic [46:0]        s3_wdd;
  logic [S0_W-1:0]    s0;
  logic signed [S1_W-1:0] s1;
  logic [S2_W-1:0]    s2;

  always_comb begin
    p_x    = XW'(peak_index);
    s_x    = XW'(seed_half_bins);
    cmax_x = XW'(count_eff) - 1'b1;
    blo_x  = (p_x >= s_x) ? (p_x - s_x) : '0;
    bhi_x  = p_x + s_x;
    if (bhi_x > cmax_x) begin
      bhi_x = cmax_x;
    end
  end

  assign d0      = 9'(XW'(addr) - p_x);
  assign dd_full = s1_d * s1_d;
  assign rd_s    = rd_data;
  assign wd_full = s2_w * s2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      s3_v   <= 1'b0;
    end else begin
      s1_v <= active;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (cmd.scan_go) begin
        // a peak beyond a lowered count leaves an empty window
        active <= (blo_x <= bhi_x);
      end else if (active && (addr == last_addr)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_go) begin
      addr      <= blo_x[AW-1:0];
      last_addr <= bhi_x[AW-1:0];
      s0        <= '0;
      s1        <= '0;
      s2        <= '0;
    end else begin
      if (active) begin
        addr <= addr + 1'b1;
      end
      if (s3_v && s3_pos) begin
        s0 <= s0 + S0_W'(s3_w);
        s1 <= s1 + S1_W'(s3_wd);
        s2 <= s2 + S2_W'(s3_wdd);
      end
    end
    s1_d   <= d0;
    s2_d   <= s1_d;
    s2_dd  <= dd_full[15:0];
    s2_w   <= rd_s;
    s3_pos <= s2_w > 32'sd0;
    s3_w   <= s2_w[30:0];
    s3_wd  <= wd_full;
    s3_wdd <= s2_w[30:0] * s2_dd;
  end

  // ---- divide and root ----
  logic [S1_W-1:0]   s1_mag;
  logic [DIV_W-1:0]  dividend;
  logic [DIV_W-1:0]  quotient;
  logic              div_busy, div_done;
  div_sel_t          div_sel_q;
  logic [MEAN_W-1:0] mmag;
  logic [VAR_W-1:0]  avar;
  logic [VAR_W-1:0]  var_r;
  logic [ROOT_W-1:0] root;
  logic              sqrt_busy;

  assign s1_mag   = s1[S1_W-1] ? S1_W'(-s1) : S1_W'(s1);
  assign dividend = (cmd.div_sel == DIV_MEAN) ? DIV_W'({s1_mag, 16'b0})
                                              : {s2[DIV_W-33:0], 32'b0};

  hpw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (dividend),
    .divisor  (s0),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  hpw_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.sqrt_go),
    .radicand (var_r),
    .busy     (sqrt_busy),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      div_sel_q <= cmd.div_sel;
    end
    if (div_done) begin
      if (div_sel_q == DIV_MEAN) begin
        mmag <= quotient[MEAN_W-1:0];
      end else begin
        avar <= quotient[VAR_W-1:0];
      end
    end
  end

  // ---- shared multiplier: product registered, then applied ----
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  mul_op_t            op_q;
  logic               mv_q;
  logic [SIG_W-1:0]   tval;
  logic [SIG_W-1:0]   sigma;
  logic [HALF_W-1:0]  half;
  logic [HALF_W-1:0]  lim;
  logic [SIG_W-1:0]   off;
  logic [CEN_W-1:0]   centre;
  logic [SPAN_W-1:0]  span;

  always_comb begin
    mul_a = '0;
    mul_b = bin_size;
    case (cmd.mul_op)
      MUL_MSQ: begin
        mul_a = MUL_A_W'(mmag);
        mul_b = MUL_B_W'(mmag);
      end
      MUL_SIGMA:    mul_a = MUL_A_W'(root);
      MUL_SEED:     mul_a = MUL_A_W'(seed_half_bins);
      MUL_FALLBACK: begin
        mul_a = tval;
        mul_b = MUL_B_W'(FALLBACK_Q16);
      end
      MUL_HALF: begin
        mul_a = sigma;
        mul_b = MUL_B_W'(sigma_multiple);
      end
      MUL_MINLIM:   mul_a = MUL_A_W'(min_half_bins);
      MUL_MAXLIM:   mul_a = MUL_A_W'(max_half_bins);
      MUL_OFF:      mul_a = MUL_A_W'(mmag);
      MUL_CENTRE:   mul_a = MUL_A_W'({peak_index, 1'b1});
      MUL_SPAN:     mul_a = MUL_A_W'(count_eff);
      default:      mul_a = '0;
    endcase
  end

  assign lim = HALF_W'(prod[40:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    op_q <= cmd.mul_op;
    if (mv_q) begin
      case (op_q)
        MUL_MSQ:      var_r  <= (avar > prod[VAR_W-1:0]) ? (avar - prod[VAR_W-1:0]) : '0;
        MUL_SIGMA:    sigma  <= prod[54:16];
        MUL_SEED:     tval   <= prod[SIG_W-1:0];
        MUL_FALLBACK: sigma  <= prod[54:16];
        MUL_HALF:     half   <= prod[54:12];
        MUL_MINLIM:   half   <= (half < lim) ? lim : half;
        MUL_MAXLIM:   half   <= (half > lim) ? lim : half;
        MUL_OFF:      off    <= prod[54:16];
        MUL_CENTRE:   centre <= prod[CEN_W:1];
        MUL_SPAN:     span   <= prod[SPAN_W-1:0];
        default:      ;
      endcase
    end
  end

  // ---- window and result ----
  logic signed [FW-1:0] axis_x, cen_x, off_x, half_x, span_x;
  logic signed [FW-1:0] mu, lo, hi, xmax;

  always_comb begin
    axis_x = FW'(axis_start);
    cen_x  = $signed(FW'(centre));
    off_x  = $signed(FW'(off));
    half_x = $signed(FW'(half));
    span_x = $signed(FW'(span));
    mu     = axis_x + cen_x + (s1[S1_W-1] ? -off_x : off_x);
    xmax   = axis_x + span_x;
    lo     = mu - half_x;
    hi     = mu + half_x;
    if (lo < axis_x) begin
      lo = axis_x;
    end
    if (hi > xmax) begin
      hi = xmax;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (stat.zero_run) begin
        window_lo <= '0;
        window_hi <= '0;
        centroid  <= '0;
        spread    <= '0;
        window_ok <= 1'b0;
      end else begin
        window_lo <= sat32(lo);
        window_hi <= sat32(hi);
        centroid  <= sat32(mu);
        spread    <= (sigma > SIG_W'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : sigma[30:0];
        window_ok <= hi > lo;
      end
    end
  end

  always_comb begin
    stat.load_last = accept && (widx_inc >= count_eff);
    stat.scan_busy = active | s1_v | s2_v | s3_v;
    stat.div_busy  = div_busy;
    stat.sqrt_busy = sqrt_busy;
    stat.zero_run  = !any_pos || (s0 == '0);
    stat.prod_zero = prod[54:16] == '0;
    stat.out_free  = !res_valid || !res_stall;
  end

endmodule

// ----- hdl/hpw_ctrl.sv -----
// Sequencer: load, scan, divides, root, multiply steps, result.
module hpw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  hpw_pkg::status_t stat,
  output hpw_pkg::cmd_t    cmd
);
  import hpw_pkg::*;

  ctrl_state_t state, state_next;
  mul_op_t     op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      op    <= MUL_MSQ;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      ST_LOAD:    if (stat.load_last) state_next = ST_SCAN_GO;
      ST_SCAN_GO: state_next = ST_SCAN;
      ST_SCAN: begin
        if (!stat.scan_busy) begin
          state_next = stat.zero_run ? ST_FINAL : ST_DIVM_GO;
        end
      end
      ST_DIVM_GO: state_next = ST_DIVM;
      ST_DIVM:    if (!stat.div_busy) state_next = ST_DIVV_GO;
      ST_DIVV_GO: state_next = ST_DIVV;
      ST_DIVV: begin
        if (!stat.div_busy) begin
          state_next = ST_MUL_GO;
          op_next    = MUL_MSQ;
        end
      end
      ST_MUL_GO:  state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        state_next = ST_MUL_GO;
        unique case (op)
          MUL_MSQ:      state_next = ST_SQRT_GO;
          MUL_SIGMA:    op_next = stat.prod_zero ? MUL_SEED : MUL_HALF;
          MUL_SEED:     op_next = MUL_FALLBACK;
          MUL_FALLBACK: op_next = MUL_HALF;
          MUL_HALF:     op_next = MUL_MINLIM;
          MUL_MINLIM:   op_next = MUL_MAXLIM;
          MUL_MAXLIM:   op_next = MUL_OFF;
          MUL_OFF:      op_next = MUL_CENTRE;
          MUL_CENTRE:   op_next = MUL_SPAN;
          MUL_SPAN:     state_next = ST_FINAL;
          default:      state_next = ST_FINAL;
        endcase
      end
      ST_SQRT_GO: state_next = ST_SQRT;
      ST_SQRT: begin
        if (!stat.sqrt_busy) begin
          state_next = ST_MUL_GO;
          op_next    = MUL_SIGMA;
        end
      end
      ST_FINAL:   if (stat.out_free) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_op  = op;
    cmd.div_sel = DIV_MEAN;
    unique case (state)
      ST_LOAD:    cmd.load_en = 1'b1;
      ST_SCAN_GO: cmd.scan_go = 1'b1;
      ST_DIVM_GO: cmd.div_go  = 1'b1;
      ST_DIVV_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_VAR;
      end
      ST_MUL_GO:  cmd.mul_go  = 1'b1;
      ST_SQRT_GO: cmd.sqrt_go = 1'b1;
      ST_FINAL:   cmd.finish  = stat.out_free;
      default:    ;
    endcase
  end

endmodule

// ----- hdl/histogram_peak_window_top.sv -----
// Top level of the histogram peak window block: config registers and sub-units.
//
// Bins stream in on the bin channel at one beat per cycle while bin_stall is low,
// in bin order, and are written to an on-chip store while the first largest bin
// is tracked. The beat that brings the load count up to bin_count ends the run;
// bin_stall then stays high while the block sums weight, weight*offset and
// weight*offset^2 over the seed window around the peak (positive bins only),
// divides, takes the square root and forms the window. One run costs its load
// beats plus the finishing work: the window scan through the store's single read
// port and its short pipe, two bit-serial divides, a bit-serial root and eight
// steps of one shared multiplier; a zero spread adds two more steps. The result
// beat is held in an output register, so the next run can load while it waits;
// a run only stalls on completion if the previous result has still not been
// taken. A histogram with no positive bin, or no positive bin in the window,
// gives an all-zero beat with window_ok low. Configuration is written through
// cfg_we/cfg_index/cfg_data and should only change while the block is between
// runs.
module histogram_peak_window_top #(
  parameter int MAX_BINS = hpw_pkg::MAX_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hpw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              bin_valid,
  output logic                              bin_stall,
  input  logic signed [31:0]                bin_weight,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [31:0]                window_lo,
  output logic signed [31:0]                window_hi,
  output logic signed [31:0]                centroid,
  output logic [30:0]                       spread,
  output logic                              window_ok
);
  import hpw_pkg::*;

  logic [10:0]        bin_count;
  logic signed [31:0] axis_start;
  logic [30:0]        bin_size;
  logic [7:0]         seed_half_bins;
  logic [15:0]        sigma_multiple;
  logic [9:0]         min_half_bins;
  logic [9:0]         max_half_bins;

  cmd_t    cmd;
  status_t stat;

  // config registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count      <= 11'd100;
      axis_start     <= '0;
      bin_size       <= 31'd65536;
      seed_half_bins <= 8'd10;
      sigma_multiple <= 16'd4096;
      min_half_bins  <= 10'd4;
      max_half_bins  <= 10'd25;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BIN_COUNT:  bin_count      <= cfg_data[10:0];
        REG_AXIS_START: axis_start     <= $signed(cfg_data);
        REG_BIN_SIZE:   bin_size       <= cfg_data[30:0];
        REG_SEED_HALF:  seed_half_bins <= cfg_data[7:0];
        REG_SIGMA_MULT: sigma_multiple <= cfg_data[15:0];
        REG_MIN_HALF:   min_half_bins  <= cfg_data[9:0];
        REG_MAX_HALF:   max_half_bins  <= cfg_data[9:0];
        default:        ;
      endcase
    end
  end

  // bins are only taken while the sequencer is loading
  assign bin_stall = !cmd.load_en;

  hpw_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  hpw_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .bin_count      (bin_count),
    .axis_start     (axis_start),
    .bin_size       (bin_size),
    .seed_half_bins (seed_half_bins),
    .sigma_multiple (sigma_multiple),
    .min_half_bins  (min_half_bins),
    .max_half_bins  (max_half_bins),
    .bin_valid      (bin_valid),
    .bin_weight     (bin_weight),
    .res_stall      (res_stall),
    .res_valid      (res_valid),
    .window_lo      (window_lo),
    .window_hi      (window_hi),
    .centroid       (centroid),
    .spread         (spread),
    .window_ok      (window_ok)
  );

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the histogram peak window block.
module testbench;
  import hpw_pkg::*;

  // One expected result beat.
  typedef struct {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] cen;
    logic [30:0]        spread;
    logic               ok;
  } window_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BIN_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  bin_valid = 1'b0;
  logic                  bin_stall;
  logic signed [31:0]    bin_weight = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic signed [31:0]    window_lo, window_hi, centroid;
  logic [30:0]           spread;
  logic                  window_ok;

  histogram_peak_window_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .bin_valid(bin_valid), .bin_stall(bin_stall), .bin_weight(bin_weight),
    .res_valid(res_valid), .res_stall(res_stall),
    .window_lo(window_lo), .window_hi(window_hi), .centroid(centroid),
    .spread(spread), .window_ok(window_ok)
  );

  always #5 clk = ~clk;

  // Predictor state: a private copy of the registers and of the run.
  int unsigned  m_count, m_size, m_seed, m_mult, m_min, m_max;
  longint       m_axis;
  int           m_store [MAX_BINS_DEF];
  int unsigned  m_load;
  longint       m_peak;
  int unsigned  m_peak_idx;
  bit           m_any_pos;

  window_t pending_windows[$];
  int      mismatches = 0;
  int      bins_sent = 0;
  bit      quiet = 1'b0;     // no idling on either side while set
  bit      hold_req = 1'b0;  // asks the receiver for a long hold-off
  int      hold_left = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void restart_run();
    m_load = 0;
    m_peak = -64'sd2147483648;
    m_peak_idx = 0;
    m_any_pos = 1'b0;
  endfunction

  // Moments over the seed window, then mean, sigma and the clamped window.
  function automatic window_t window_from_run(input int unsigned count);
    window_t r;
    longint p, bs, seed, blo, bhi, w, d, s1, off, mu, sigma, half, lim, lo, hi, xmax;
    longint unsigned s0, s2, mag, q, rem, mmag, f1, r1, f2, a, msq, var_q;
    r = '{lo: 0, hi: 0, cen: 0, spread: 0, ok: 0};
    if (!m_any_pos) return r;
    p = m_peak_idx; bs = m_size; seed = m_seed;
    blo = p - seed; bhi = p + seed;
    if (blo < 0) blo = 0;
    if (bhi > longint'(count) - 1) bhi = longint'(count) - 1;
    s0 = 0; s1 = 0; s2 = 0;
    for (longint b = blo; b <= bhi; b++) begin
      w = m_store[b & (MAX_BINS_DEF - 1)];
      d = b - p;
      if (w > 0) begin
        s0 += w;
        s1 += w * d;
        s2 += w * d * d;
      end
    end
    if (s0 == 0) return r;
    mag = (s1 < 0) ? -s1 : s1;
    q = mag / s0; rem = mag % s0;
    mmag = (q << 16) + ((rem << 16) / s0);
    q = s2 / s0; rem = s2 % s0;
    f1 = (rem << 16) / s0; r1 = (rem << 16) % s0;
    f2 = (r1 << 16) / s0;
    a = (q << 32) + (f1 << 16) + f2;
    msq = mmag * mmag;
    var_q = (a > msq) ? a - msq : 0;
    off = longint'((mmag * longint'(m_size)) >> 16);
    if (s1 < 0) off = -off;
    mu = m_axis + ((2 * p + 1) * bs) / 2 + off;
    sigma = longint'((root64(var_q) * longint'(m_size)) >> 16);
    if (sigma <= 0)  // zero spread: fall back to 0.35 seed half-widths
      sigma = longint'((longint'(m_seed) * longint'(m_size) * 22938) >> 16);
    half = longint'((longint'(m_mult) * sigma) >> 12);
    lim = longint'(m_min) * bs;
    if (half < lim) half = lim;
    lim = longint'(m_max) * bs;  // upper clamp wins when clamps cross
    if (half > lim) half = lim;
    lo = mu - half; hi = mu + half;
    xmax = m_axis + longint'(count) * bs;
    if (lo < m_axis) lo = m_axis;
    if (hi > xmax) hi = xmax;
    r.lo = sat32(lo);
    r.hi = sat32(hi);
    r.cen = sat32(mu);
    r.spread = (sigma > 64'sd2147483647) ? 31'h7fffffff : sigma[30:0];
    r.ok = hi > lo;
    return r;
  endfunction

  // Advance the predictor by one accepted bin; queue a result at run end.
  function automatic void predict_window_on_bin(input logic signed [31:0] wt);
    int unsigned count, idx;
    longint w;
    count = (m_count == 0) ? 1 : (m_count > MAX_BINS_DEF) ? MAX_BINS_DEF : m_count;
    w = wt;
    idx = (m_load >= MAX_BINS_DEF) ? MAX_BINS_DEF - 1 : m_load;
    m_store[idx] = wt;
    if (w > m_peak) begin
      m_peak = w;
      m_peak_idx = idx;
    end
    if (w > 0) m_any_pos = 1'b1;
    m_load = idx + 1;
    if (m_load >= count) begin
      pending_windows.push_back(window_from_run(count));
      restart_run();
    end
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_BIN_COUNT:  m_count = val[10:0];
      REG_AXIS_START: m_axis = longint'(signed'(val));
      REG_BIN_SIZE:   m_size = val[30:0];
      REG_SEED_HALF:  m_seed = val[7:0];
      REG_SIGMA_MULT: m_mult = val[15:0];
      REG_MIN_HALF:   m_min = val[9:0];
      REG_MAX_HALF:   m_max = val[9:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_bin(input logic signed [31:0] w);
    while (!quiet && $urandom_range(99) < 6) begin
      bin_valid <= 1'b0;
      @(posedge clk);
    end
    bin_valid <= 1'b1;
    bin_weight <= w;
    do @(posedge clk); while (bin_stall);
    predict_window_on_bin(w);
    bins_sent++;
  endtask

  task automatic drain();
    bin_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Bin content: 0 shaped peak, 1 any 32-bit value, 2 nothing positive, 3 extremes.
  function automatic logic signed [31:0] bin_value(input int kind, input int i,
                                                   input int ctr, input int wid);
    int gap;
    gap = (i > ctr) ? i - ctr : ctr - i;
    case (kind)
      0: begin
        if (gap <= wid) return $urandom_range(1, 1 << 16) * (wid + 1 - gap);
        if ($urandom_range(3) == 0) return -$signed($urandom_range(1000));
        return $urandom_range(50);
      end
      1: return $urandom;
      2: return -$signed($urandom_range(32'h7fffffff));
      default: return (i % 2) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  task automatic send_run(input int n, input int kind);
    int ctr, wid;
    ctr = $urandom_range(n - 1);
    wid = $urandom_range(4);
    for (int i = 0; i < n; i++) send_bin(bin_value(kind, i, ctr, wid));
  endtask

  task automatic set_all(input logic [31:0] cnt, input logic [31:0] axis,
                         input logic [31:0] bsz, input logic [31:0] seed,
                         input logic [31:0] mult, input logic [31:0] mn,
                         input logic [31:0] mx);
    write_reg(REG_BIN_COUNT, cnt);
    write_reg(REG_AXIS_START, axis);
    write_reg(REG_BIN_SIZE, bsz);
    write_reg(REG_SEED_HALF, seed);
    write_reg(REG_SIGMA_MULT, mult);
    write_reg(REG_MIN_HALF, mn);
    write_reg(REG_MAX_HALF, mx);
    end_writes();
  endtask

  // Result side: random stall, long hold-off on request, and the checker.
  always @(posedge clk) begin
    window_t e;
    if (res_valid && !res_stall) begin
      if (pending_windows.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = pending_windows.pop_front();
        if (window_lo !== e.lo)
          report_mismatch($sformatf("window_lo %h exp %h", window_lo, e.lo));
        if (window_hi !== e.hi)
          report_mismatch($sformatf("window_hi %h exp %h", window_hi, e.hi));
        if (centroid !== e.cen)
          report_mismatch($sformatf("centroid %h exp %h", centroid, e.cen));
        if (spread !== e.spread)
          report_mismatch($sformatf("spread %h exp %h", spread, e.spread));
        if (window_ok !== e.ok)
          report_mismatch($sformatf("window_ok %b exp %b", window_ok, e.ok));
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !quiet && ($urandom_range(99) < 6);
    end
  end

  // Power-on settings, one shaped run of the default size.
  task automatic test_defaults();
    send_run(100, 0);
    drain();
  endtask

  // Count of zero acts as one; a one-bin run; wide settings on a short run.
  task automatic test_count_limits();
    set_all(0, 0, 32'h10000, 10, 4096, 4, 25);
    send_bin(32'sh7fffffff);
    drain();
    set_all(1, 0, 32'h10000, 10, 4096, 4, 25);
    send_bin(32'sh80000000);
    drain();
    set_all(20, 32'h80000000, 32'h100, 255, 65535, 0, 1023);
    send_run(20, 0);
    drain();
  endtask

  // No positive bin anywhere gives an all-zero beat; then a run of alternating extremes.
  task automatic test_empty();
    set_all(6, 32'h12345678, 32'h10000, 3, 4096, 4, 25);
    send_run(6, 2);
    drain();
    send_run(6, 3);
    drain();
  endtask

  // Count lowered while a run is part loaded: the next bin ends it, and a peak
  // beyond the new end leaves no window weight.
  task automatic test_count_lowered();
    set_all(10, 0, 32'h10000, 1, 4096, 4, 25);
    for (int i = 0; i < 5; i++) send_bin(i == 4 ? 32'sh1000 : -32'sd5);
    drain();
    write_reg(REG_BIN_COUNT, 3);
    end_writes();
    send_bin(32'sd1);
    drain();
  endtask

  // Saturation, zero bin size, crossed clamps, zero seed and multiplier.
  task automatic test_wide_values();
    set_all(8, 32'h7fffffff, 32'h7fffffff, 255, 65535, 1023, 1023);
    send_run(8, 0);
    drain();
    set_all(4, 32'h80000000, 0, 2, 4096, 4, 25);
    send_run(4, 0);
    drain();
    set_all(5, 32'hfff00000, 32'h8000, 0, 0, 900, 3);
    send_run(5, 0);
    drain();
  endtask

  // Receiver holds off while the sender keeps going, so the block fills up.
  task automatic test_backpressure();
    set_all(4, 0, 32'h10000, 2, 8192, 1, 10);
    hold_req = 1'b1;
    for (int r = 0; r < 5; r++) send_run(4, 0);
    drain();
  endtask

  task automatic random_config();
    logic [31:0] axis, bsz;
    case ($urandom_range(3))
      0: axis = 32'h80000000;
      1: axis = 32'h7fffffff;
      default: axis = $urandom;
    endcase
    case ($urandom_range(4))
      0: bsz = 1;
      1: bsz = 32'h7fffffff;
      default: bsz = $urandom_range(1, 32'h40000);
    endcase
    set_all($urandom_range(1, 16), axis, bsz,
            $urandom_range(3) == 0 ? 255 : $urandom_range(8),
            $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(2048, 12288),
            $urandom_range(3) == 0 ? 1023 : $urandom_range(6),
            $urandom_range(3) == 0 ? 1023 : $urandom_range(40));
  endtask

  // Mostly shaped histograms with random content, some pure noise or nothing positive.
  task automatic test_random();
    int runs, n;
    runs = 0;
    while (bins_sent < 650) begin
      if (runs % 4 == 0) random_config();
      quiet = (runs >= 20 && runs < 30);
      n = (m_count == 0) ? 1 : m_count;
      send_run(n, $urandom_range(9) < 7 ? 0 : $urandom_range(1, 2));
      runs++;
      if (runs % 4 == 0) drain();
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    m_count = 100; m_axis = 0; m_size = 65536; m_seed = 10;
    m_mult = 4096; m_min = 4; m_max = 25;
    restart_run();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_count_limits();
    test_empty();
    test_count_lowered();
    test_wide_values();
    test_backpressure();
    test_random();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_windows.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/hpw_pkg.sv
hdl/hpw_div.sv
hdl/hpw_sqrt.sv
hdl/hpw_datapath.sv
hdl/hpw_ctrl.sv
hdl/histogram_peak_window_top.sv
bench/testbench.sv
